@@ src/hipt_pkg.sv @@
// Package: shared constants, opcodes, status codes and a Q1.31 multiply for the probability table.
package hipt_pkg;
  localparam int unsigned MaxHhDefault = 16;
  localparam logic [31:0] OneQ31 = 32'h8000_0000;

  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE     = 2'd1;
  localparam logic [1:0] ST_NOT_BUILT = 2'd2;

  localparam logic CFG_ATTACK_RATE   = 1'b0;
  localparam logic CFG_HOUSEHOLD_MAX = 1'b1;

  // Truncating Q1.31 product.
  function automatic logic [31:0] qmul(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = {32'd0, a} * {32'd0, b};
    return p[62:31];
  endfunction
endpackage

@@ src/hipt_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module hipt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ src/household_infection_probability_table.sv @@
// Top level: chain-binomial household secondary-infection probability table.
//
// A build word (opcode 0) clears the table memory and then fills the
// triangular table of P(j secondaries | k primaries, m susceptibles) for all
// k+m <= n, where n is household_max saturated to MAX_HH and q is
// attack_rate saturated to 1.0 (Q1.31). A read word (opcode 1) returns one
// stored probability with status ok, out of range, or not built. One word is
// handled at a time. A read first forms the address and checks the range,
// then covers the registered memory read, after which its result word is
// valid. The input stays stalled while the result waits, so a new read is
// not taken until the last result has been taken. A build is a sequenced
// pass through the table memory's one write and one read port: a clearing
// sweep of one entry per cycle over the whole table depth (969 entries at
// MAX_HH = 16), a power pass writing MAX_HH + 1 escape powers, and then a
// run state and a next state for each (k, m) run plus its updates. Within a
// run with m > 0, each i term reads the previous run entry and the escape
// power, forms both products, then reads and saturates a write back; the
// products step is skipped when k + i is zero. Each j update reads the
// k = 1 run entry, reads the target while multiplying, and writes back.
// A final done state presents the result. The result word of a build
// carries probability 0 and status ok.
module household_infection_probability_table #(
  parameter int unsigned MAX_HH = hipt_pkg::MaxHhDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [4:0]  primaries,
  input  logic [4:0]  susceptibles,
  input  logic [4:0]  secondaries,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] probability,
  output logic [1:0]  status
);
  localparam int unsigned Depth = MAX_HH * (MAX_HH * MAX_HH + 6 * MAX_HH + 11) / 6 + 1;
  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned EW = $clog2(MAX_HH + 1);
  localparam int unsigned CW = EW + 1;
  localparam int unsigned BW = AW + 1;
  localparam int unsigned XW = CW + 1;
  localparam int unsigned SW = 2 * CW;

  typedef enum logic [3:0] {
    S_IDLE, S_READ_ADDR, S_READ_MEM, S_CLEAR, S_POW, S_RUN, S_UPD_RD, S_UPD_MUL,
    S_INNER_RD, S_INNER_MUL, S_ADD_RD, S_ADD_WR, S_NEXT, S_DONE
  } state_t;

  state_t state;
  logic [31:0] attack_rate;
  logic [4:0]  household_max;
  logic        table_built;
  logic [EW-1:0] built_n;

  // Build loop counters.
  logic [CW-1:0] n, k, m, i, j;
  logic [AW-1:0] cur, prev, g1, clr;
  logic [31:0]   esc, pv, ex, hit, addv;
  logic          inner; // add is for the j loop rather than the i term
  logic [EW-1:0] e;

  // Escape power memory.
  logic          pw_we;
  logic [EW-1:0] pw_waddr, pw_raddr;
  logic [31:0]   pw_wdata, pw_rdata, pw_last;

  // Table memory.
  logic          tb_we;
  logic [AW-1:0] tb_waddr, tb_raddr;
  logic [31:0]   tb_wdata, tb_rdata;

  logic [4:0]  rk, rm, rj;
  logic [1:0]  rstat;

  // Tetrahedral number x(x+1)(x+2)/6 for x up to MAX_HH + 1, as a constant lookup.
  function automatic logic [BW-1:0] tet(input logic [XW-1:0] x);
    logic [BW-1:0] r;
    r = '0;
    for (int t = 0; t <= int'(MAX_HH) + 1; t++) begin
      if (int'(x) == t) begin
        r = BW'(t * (t + 1) * (t + 2) / 6);
      end
    end
    return r;
  endfunction

  // Run base for (kk, mm) in a table of size nn. The runs of the primary
  // counts below kk hold tet(nn+1) - tet(nn+1-kk) entries.
  function automatic logic [AW-1:0] run_base(input logic [CW-1:0] nn,
                                             input logic [CW-1:0] kk,
                                             input logic [CW-1:0] mm);
    logic [XW-1:0] top, low;
    logic [SW-1:0] mm_sq;
    top   = {1'b0, nn} + XW'(1);
    low   = top - {1'b0, kk};
    mm_sq = SW'(mm) * (SW'(mm) + SW'(1));
    return AW'(tet(top) - tet(low) + BW'(mm_sq >> 1));
  endfunction

  hipt_ram #(.Width(32), .Depth(Depth)) u_table (
    .clk, .we(tb_we), .waddr(tb_waddr), .wdata(tb_wdata), .raddr(tb_raddr),
    .rdata(tb_rdata)
  );
  hipt_ram #(.Width(32), .Depth(MAX_HH + 1)) u_pow (
    .clk, .we(pw_we), .waddr(pw_waddr), .wdata(pw_wdata), .raddr(pw_raddr),
    .rdata(pw_rdata)
  );

  assign in_stall = (state != S_IDLE) || out_valid;

  logic [CW:0] kpi;
  assign kpi = {1'b0, k} + {1'b0, i};

  // Sum of the stored entry and the addend; the write back saturates it at one.
  logic [32:0] sum;
  assign sum = {1'b0, tb_rdata} + {1'b0, addv};

  always_comb begin
    tb_we    = 1'b0;
    tb_waddr = clr;
    tb_wdata = 32'd0;
    tb_raddr = AW'(32'(run_base(CW'(built_n), CW'(rk), CW'(rm))) + 32'(rj));
    pw_we    = 1'b0;
    pw_waddr = e;
    pw_wdata = hipt_pkg::qmul(pw_last, esc);
    pw_raddr = kpi[EW-1:0];
    case (state)
      S_CLEAR: begin
        tb_we = 1'b1;
      end
      S_POW: begin
        pw_we = 1'b1;
      end
      S_RUN: begin
        tb_we    = (m == '0);
        tb_waddr = run_base(n, k, m);
        tb_wdata = hipt_pkg::OneQ31;
        tb_raddr = AW'(prev + AW'(i));
      end
      S_UPD_RD: begin
        tb_raddr = AW'(prev + AW'(i));
      end
      S_INNER_RD: begin
        tb_raddr = AW'(g1 + AW'(j));
      end
      S_ADD_RD: begin
        tb_raddr = inner ? AW'(cur + AW'(i) + AW'(j) + AW'(1)) : AW'(cur + AW'(i));
      end
      S_ADD_WR: begin
        tb_we    = 1'b1;
        tb_waddr = inner ? AW'(cur + AW'(i) + AW'(j) + AW'(1)) : AW'(cur + AW'(i));
        tb_wdata = sum > {1'b0, hipt_pkg::OneQ31} ? hipt_pkg::OneQ31 : sum[31:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      attack_rate   <= 32'd0;
      household_max <= 5'd16;
      table_built   <= 1'b0;
      built_n       <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          hipt_pkg::CFG_ATTACK_RATE:   attack_rate <= cfg_data;
          hipt_pkg::CFG_HOUSEHOLD_MAX: household_max <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            rk <= primaries;
            rm <= susceptibles;
            rj <= secondaries;
            if (opcode == hipt_pkg::OP_READ) begin
              state <= S_READ_ADDR;
            end else begin
              clr   <= '0;
              esc   <= hipt_pkg::OneQ31 -
                       (attack_rate > hipt_pkg::OneQ31 ? hipt_pkg::OneQ31 : attack_rate);
              n     <= (32'(household_max) > MAX_HH) ? CW'(MAX_HH) : CW'(household_max);
              state <= S_CLEAR;
            end
          end
        end
        S_READ_ADDR: begin
          if (!table_built) begin
            rstat <= hipt_pkg::ST_NOT_BUILT;
          end else if (32'(rk) + 32'(rm) > 32'(built_n) || rj > rm) begin
            rstat <= hipt_pkg::ST_RANGE;
          end else begin
            rstat <= hipt_pkg::ST_OK;
          end
          state <= S_READ_MEM;
        end
        S_READ_MEM: begin
          probability <= (rstat == hipt_pkg::ST_OK) ? tb_rdata : 32'd0;
          status      <= rstat;
          out_valid   <= 1'b1;
          state       <= S_IDLE;
        end
        S_CLEAR: begin
          clr <= clr + AW'(1);
          if (32'(clr) == Depth - 1) begin
            e       <= '0;
            pw_last <= hipt_pkg::OneQ31;
            state   <= S_POW;
          end
        end
        S_POW: begin
          // Entries 0 and 1 both hold the escape term; later entries are the running product.
          if (e == '0) begin
            pw_last <= hipt_pkg::OneQ31;
          end else begin
            pw_last <= pw_wdata;
          end
          e <= e + EW'(1);
          if (32'(e) == MAX_HH) begin
            k     <= '0;
            m     <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          cur <= run_base(n, k, m);
          i   <= '0;
          state <= (m == '0) ? S_NEXT : S_UPD_RD;
        end
        S_UPD_RD: begin
          g1    <= run_base(n, CW'(1), CW'(m - i - CW'(1)));
          state <= S_UPD_MUL;
        end
        S_UPD_MUL: begin
          pv <= tb_rdata;
          ex <= pw_rdata;
          if (kpi == '0) begin
            addv  <= tb_rdata;
            inner <= 1'b0;
            state <= S_ADD_RD;
          end else begin
            state <= S_INNER_MUL;
            inner <= 1'b1;
            j     <= '0;
          end
        end
        S_INNER_MUL: begin
          // Once per i term: form the escape term and the hit factor.
          addv  <= hipt_pkg::qmul(pv, ex);
          hit   <= hipt_pkg::qmul(pv, hipt_pkg::OneQ31 - ex);
          inner <= 1'b0;
          state <= S_ADD_RD;
        end
        S_INNER_RD: begin
          state <= S_ADD_RD;
        end
        S_ADD_RD: begin
          if (inner) begin
            addv <= hipt_pkg::qmul(hit, tb_rdata);
          end
          state <= S_ADD_WR;
        end
        S_ADD_WR: begin
          if (!inner) begin
            if (kpi == '0) begin
              state <= S_NEXT;
            end else begin
              inner <= 1'b1;
              j     <= '0;
              state <= S_INNER_RD;
            end
          end else if (j + i + CW'(1) < m) begin
            j     <= j + CW'(1);
            state <= S_INNER_RD;
          end else begin
            state <= S_NEXT;
          end
          if (state == S_ADD_WR && (kpi == '0 || inner) &&
              !(inner && j + i + CW'(1) < m)) begin
            if (i + CW'(1) < m) begin
              i     <= i + CW'(1);
              state <= S_UPD_RD;
            end
          end
        end
        S_NEXT: begin
          prev <= cur;
          if (m + k < n) begin
            m     <= m + CW'(1);
            state <= S_RUN;
          end else if (k < n) begin
            k     <= k + CW'(1);
            m     <= '0;
            state <= S_RUN;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          table_built <= 1'b1;
          built_n     <= n[EW-1:0];
          probability <= 32'd0;
          status      <= hipt_pkg::ST_OK;
          out_valid   <= 1'b1;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result is presented only once the sequencer has returned to idle.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> state == S_IDLE)
    else $error("result raised while sequencer busy");
  // Nothing is accepted while a result waits.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted with result pending");
  // Before a build, a result reports a status other than ok or probability 0.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !table_built) |-> status != hipt_pkg::ST_OK || probability == 32'd0)
    else $error("ok read before build");
endmodule
